/* src/fgcc_pkg.sv */
// ----------------------------------------------------------------------------
// fgcc_pkg
// Types and constants shared by the grid clip classifier modules.
// ----------------------------------------------------------------------------
package fgcc_pkg;

    localparam int MAX_TILES_SIDE = 32;
    localparam int MAX_PATCH_SIDE = 7;
    localparam int TW             = 5;      // tile coordinate bits
    localparam int DW             = 6;      // tile count bits
    localparam int PW             = 3;      // patch side bits
    localparam int VERT_DEPTH     = (MAX_TILES_SIDE + 1) * (MAX_TILES_SIDE + 1);
    localparam int VW             = 11;     // vertex index bits
    localparam int TILE_DEPTH     = MAX_TILES_SIDE * MAX_TILES_SIDE;

    localparam logic [1:0] REG_TILE_COLS = 2'd0;
    localparam logic [1:0] REG_TILE_ROWS = 2'd1;
    localparam logic [1:0] REG_TPP       = 2'd2;

    localparam logic [1:0] FLAG_CLEAR = 2'd0;
    localparam logic [1:0] FLAG_HIT   = 2'd1;
    localparam logic [1:0] FLAG_MIXED = 2'd2;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_QTILE   = 2'd2,
        CMD_QPATCH  = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUERY,
        ST_TILE,
        ST_TDRAIN,
        ST_PATCH,
        ST_PDRAIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic out_now;
        logic tile_run;
        logic patch_run;
        logic out_query;
        logic out_class;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
        logic load_trig;
        logic tile_last;
        logic patch_last;
    } t_dp_stat;

endpackage

/* src/fgcc_ctrl.sv */
// ----------------------------------------------------------------------------
// fgcc_ctrl
// Sequencer: word acceptance, query wait and the two classification passes.
// ----------------------------------------------------------------------------
module fgcc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  fgcc_pkg::t_cmd_code i_cmd,
    input  fgcc_pkg::t_dp_stat  i_stat,
    input  logic                i_out_ready,
    output fgcc_pkg::t_dp_cmd   o_cmd
);
    import fgcc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = !i_stat.out_valid || i_out_ready;
                if (i_valid && o_ready) begin
                    o_cmd.accept = 1'b1;
                    case (i_cmd)
                        CMD_QTILE, CMD_QPATCH: n_state = ST_QUERY;
                        default: begin
                            if (i_cmd == CMD_LOAD && i_stat.load_trig) begin
                                n_state = ST_TILE;
                            end else begin
                                o_cmd.out_now = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_QUERY: begin
                o_cmd.out_query = 1'b1;
                n_state = ST_IDLE;
            end
            ST_TILE: begin
                o_cmd.tile_run = 1'b1;
                if (i_stat.tile_last) begin
                    n_state = ST_TDRAIN;
                end
            end
            ST_TDRAIN: begin
                n_state = ST_PATCH;
            end
            ST_PATCH: begin
                o_cmd.patch_run = 1'b1;
                if (i_stat.patch_last) begin
                    n_state = ST_PDRAIN;
                end
            end
            ST_PDRAIN: begin
                o_cmd.out_class = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* src/fgcc_datapath.sv */
// ----------------------------------------------------------------------------
// fgcc_datapath
// Vertex, tile and patch maps, pass counters and the output register.
// ----------------------------------------------------------------------------
module fgcc_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fgcc_pkg::t_dp_cmd         i_cmd,
    output fgcc_pkg::t_dp_stat        o_stat,
    input  fgcc_pkg::t_cmd_code       i_in_cmd,
    input  logic                      i_in_hit,
    input  logic [fgcc_pkg::TW-1:0]   i_in_col,
    input  logic [fgcc_pkg::TW-1:0]   i_in_row,
    input  logic [fgcc_pkg::DW-1:0]   i_cols,
    input  logic [fgcc_pkg::DW-1:0]   i_rows,
    input  logic [fgcc_pkg::PW-1:0]   i_tpp,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [1:0]                o_flag,
    output logic                      o_classified
);
    import fgcc_pkg::*;

    logic            vmem [0:VERT_DEPTH-1];
    logic            tmem [0:TILE_DEPTH-1];
    logic [1:0]      pmem [0:TILE_DEPTH-1];

    // control
    logic            r_done;
    logic [VW-1:0]   r_count;
    logic            r_td_v, r_pd_v, r_out_v;
    // payload
    logic [DW-1:0]   r_lcols, r_lrows, r_pcols, r_prows;
    t_cmd_code       r_qcmd;
    logic [TW-1:0]   r_qcol, r_qrow;
    logic [DW-1:0]   r_tj;
    logic [TW-1:0]   r_tr;
    logic [VW-1:0]   r_va;
    logic            r_vd_a, r_vd_b, r_prev;
    logic [DW-1:0]   r_td_j;
    logic [TW-1:0]   r_td_r;
    logic [TW-1:0]   r_pr_base, r_pc_base, r_r, r_c, r_pr_i, r_pc_i;
    logic            r_pd_first, r_pd_end, r_pd_final;
    logic [TW-1:0]   r_pd_pr, r_pd_pc;
    logic            r_tq;
    logic [1:0]      r_pq;
    logic            r_any_hit, r_any_clr;
    logic [1:0]      r_flag;
    logic            r_cls;

    // load bookkeeping
    logic [13:0]     w_total;
    logic [VW-1:0]   w_count_inc;
    logic            w_trig;
    assign w_total     = ({8'd0, i_cols} + 14'd1) * ({8'd0, i_rows} + 14'd1);
    assign w_count_inc = r_count + VW'(1);
    assign w_trig      = {3'd0, w_count_inc} >= w_total;

    // tile pass
    logic            w_tile_last, w_cur;
    logic [VW-1:0]   w_vb;
    assign w_tile_last = ({1'b0, r_tr} == i_rows - 6'd1) && (r_tj == i_cols);
    assign w_vb        = r_va + VW'(i_cols) + VW'(1);
    assign w_cur       = r_vd_a | r_vd_b;

    // patch pass
    logic            w_c_edge, w_r_edge, w_c_last, w_r_last, w_final;
    assign w_c_edge = (6'(r_c) + 6'd1 == i_cols);
    assign w_r_edge = (6'(r_r) + 6'd1 == i_rows);
    assign w_c_last = w_c_edge || (7'(r_c) + 7'd1 == 7'(r_pc_base) + 7'(i_tpp));
    assign w_r_last = w_r_edge || (7'(r_r) + 7'd1 == 7'(r_pr_base) + 7'(i_tpp));
    assign w_final  = w_c_edge && w_r_edge;

    logic            w_acc_hit, w_acc_clr;
    logic [1:0]      w_pflag;
    assign w_acc_hit = r_pd_first ? r_tq  : (r_any_hit | r_tq);
    assign w_acc_clr = r_pd_first ? !r_tq : (r_any_clr | !r_tq);
    assign w_pflag   = !w_acc_clr ? FLAG_HIT : (!w_acc_hit ? FLAG_CLEAR : FLAG_MIXED);

    // query result
    logic            w_t_in, w_t_old, w_p_in;
    logic [1:0]      w_qflag;
    assign w_t_in  = ({1'b0, r_qcol} < i_cols) && ({1'b0, r_qrow} < i_rows);
    assign w_t_old = r_done && ({1'b0, r_qcol} < r_lcols) && ({1'b0, r_qrow} < r_lrows);
    assign w_p_in  = ({1'b0, r_qcol} < r_pcols) && ({1'b0, r_qrow} < r_prows);
    always_comb begin
        if (r_qcmd == CMD_QTILE) begin
            w_qflag = w_t_in ? (w_t_old ? {1'b0, r_tq} : FLAG_HIT) : FLAG_CLEAR;
        end else begin
            w_qflag = r_done ? (w_p_in ? r_pq : FLAG_CLEAR) : FLAG_HIT;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in_cmd == CMD_LOAD && !r_done
                && {3'd0, r_count} < 14'(VERT_DEPTH)) begin
            vmem[r_count] <= i_in_hit;
        end
        if (i_cmd.tile_run) begin
            r_vd_a <= vmem[r_va];
            r_vd_b <= vmem[w_vb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_td_v && r_td_j != '0) begin
            tmem[{r_td_r, TW'(r_td_j - 6'd1)}] <= r_prev | w_cur;
        end
        if (i_cmd.patch_run) begin
            r_tq <= tmem[{r_r, r_c}];
        end else begin
            r_tq <= tmem[{i_in_row, i_in_col}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pd_v && r_pd_end) begin
            pmem[{r_pd_pr, r_pd_pc}] <= w_pflag;
        end
        r_pq <= pmem[{i_in_row, i_in_col}];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_count <= '0;
            r_td_v  <= 1'b0;
            r_pd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_td_v <= i_cmd.tile_run;
            r_pd_v <= i_cmd.patch_run;
            if (i_cmd.accept && i_in_cmd == CMD_RESTART) begin
                r_done  <= 1'b0;
                r_count <= '0;
            end else if (i_cmd.accept && i_in_cmd == CMD_LOAD && !r_done) begin
                r_count <= w_trig ? VW'(w_total) : w_count_inc;
            end else if (i_cmd.out_class) begin
                r_done <= 1'b1;
            end
            if (i_cmd.out_now || i_cmd.out_query || i_cmd.out_class) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_qcmd    <= i_in_cmd;
            r_qcol    <= i_in_col;
            r_qrow    <= i_in_row;
            r_tj      <= '0;
            r_tr      <= '0;
            r_va      <= '0;
            r_pr_base <= '0;
            r_pc_base <= '0;
            r_r       <= '0;
            r_c       <= '0;
            r_pr_i    <= '0;
            r_pc_i    <= '0;
        end
        if (i_cmd.tile_run) begin
            r_va <= r_va + VW'(1);
            if (r_tj == i_cols) begin
                r_tj <= '0;
                r_tr <= r_tr + TW'(1);
            end else begin
                r_tj <= r_tj + 6'd1;
            end
        end
        r_td_j <= r_tj;
        r_td_r <= r_tr;
        if (r_td_v) begin
            r_prev <= w_cur;
        end

        if (i_cmd.patch_run) begin
            if (!w_c_last) begin
                r_c <= r_c + TW'(1);
            end else if (!w_r_last) begin
                r_c <= r_pc_base;
                r_r <= r_r + TW'(1);
            end else if (!w_c_edge) begin
                r_pc_base <= r_pc_base + TW'(i_tpp);
                r_c       <= r_pc_base + TW'(i_tpp);
                r_pc_i    <= r_pc_i + TW'(1);
                r_r       <= r_pr_base;
            end else begin
                r_pc_base <= '0;
                r_c       <= '0;
                r_pc_i    <= '0;
                r_pr_base <= r_pr_base + TW'(i_tpp);
                r_r       <= r_pr_base + TW'(i_tpp);
                r_pr_i    <= r_pr_i + TW'(1);
            end
        end
        r_pd_first <= (r_c == r_pc_base) && (r_r == r_pr_base);
        r_pd_end   <= w_c_last && w_r_last;
        r_pd_final <= w_final;
        r_pd_pr    <= r_pr_i;
        r_pd_pc    <= r_pc_i;
        if (r_pd_v) begin
            r_any_hit <= w_acc_hit;
            r_any_clr <= w_acc_clr;
            if (r_pd_final) begin
                r_pcols <= 6'(r_pd_pc) + 6'd1;
                r_prows <= 6'(r_pd_pr) + 6'd1;
            end
        end

        if (i_cmd.out_class) begin
            r_lcols <= i_cols;
            r_lrows <= i_rows;
        end
        if (i_cmd.out_now) begin
            r_flag <= FLAG_CLEAR;
            r_cls  <= (i_in_cmd == CMD_RESTART) ? 1'b0 : r_done;
        end else if (i_cmd.out_query) begin
            r_flag <= w_qflag;
            r_cls  <= r_done;
        end else if (i_cmd.out_class) begin
            r_flag <= FLAG_CLEAR;
            r_cls  <= 1'b1;
        end
    end

    assign o_stat.out_valid  = r_out_v;
    assign o_stat.load_trig  = !r_done && w_trig;
    assign o_stat.tile_last  = w_tile_last;
    assign o_stat.patch_last = w_final;
    assign o_out_valid  = r_out_v;
    assign o_flag       = r_flag;
    assign o_classified = r_cls;

endmodule

/* src/fluid_grid_clip_classifier_core.sv */
// Restart and load: one word per cycle unless the output stalls; result
// registered at the accept edge. Queries: result registered in the cycle
// after the accept, and no new word is taken while it is formed.
// The load that completes the grid runs the tile pass on the two vertex read
// ports, then the patch pass on the tile map read port, and then gives its result.
// Reset is synchronous; no clearing pass, all maps read as reset at once.
// ----------------------------------------------------------------------------
// fluid_grid_clip_classifier_core
// Top level: register port, stream ports, controller and datapath.
// ----------------------------------------------------------------------------
module fluid_grid_clip_classifier_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command[1:0], vertex_hit[2], col[7:3], row[12:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // flag[1:0], classified[2]
);
    import fgcc_pkg::*;

    logic [DW-1:0] r_cols, r_rows;
    logic [PW-1:0] r_tpp;
    logic [DW-1:0] w_cols, w_rows;
    logic [PW-1:0] w_tpp;
    logic [1:0]    w_idx;
    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    t_cmd_code     w_in_cmd;
    logic [1:0]    w_flag;
    logic          w_cls;

    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= DW'(1);
            r_rows <= DW'(1);
            r_tpp  <= PW'(MAX_PATCH_SIDE);
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_TILE_COLS: r_cols <= pwdata[DW-1:0];
                REG_TILE_ROWS: r_rows <= pwdata[DW-1:0];
                REG_TPP:       r_tpp  <= pwdata[PW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TILE_COLS: prdata = {26'd0, r_cols};
            REG_TILE_ROWS: prdata = {26'd0, r_rows};
            REG_TPP:       prdata = {29'd0, r_tpp};
            default:       prdata = '0;
        endcase
    end

    assign w_cols = (r_cols == '0) ? DW'(1) :
                    (r_cols > DW'(MAX_TILES_SIDE)) ? DW'(MAX_TILES_SIDE) : r_cols;
    assign w_rows = (r_rows == '0) ? DW'(1) :
                    (r_rows > DW'(MAX_TILES_SIDE)) ? DW'(MAX_TILES_SIDE) : r_rows;
    assign w_tpp  = (r_tpp == '0) ? PW'(1) : r_tpp;

    assign w_in_cmd = t_cmd_code'(s_tdata[1:0]);

    fgcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_cmd       (w_in_cmd),
        .i_stat      (w_stat),
        .i_out_ready (m_tready),
        .o_cmd       (w_cmd)
    );

    fgcc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_cmd     (w_in_cmd),
        .i_in_hit     (s_tdata[2]),
        .i_in_col     (s_tdata[7:3]),
        .i_in_row     (s_tdata[12:8]),
        .i_cols       (w_cols),
        .i_rows       (w_rows),
        .i_tpp        (w_tpp),
        .i_out_ready  (m_tready),
        .o_out_valid  (m_tvalid),
        .o_flag       (w_flag),
        .o_classified (w_cls)
    );

    assign m_tdata = {5'd0, w_cls, w_flag};

    a_no_accept_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !(w_cmd.tile_run || w_cmd.patch_run))
        else $error("word accepted during classification pass");

    a_class_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_class |=> m_tvalid && m_tdata[2])
        else $error("classification result not presented");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tdata[1]) |=> w_cmd.out_query && !s_tready)
        else $error("query result not formed in the following cycle");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid clip classifier: directed table, then
// random restart/load/query traffic with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
    import fgcc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [7:0]  m_tdata;

    fluid_grid_clip_classifier_core dut (.*);

    typedef struct packed {
        logic [1:0] flag;
        logic       classified;
    } t_grid_res;

    typedef struct {
        t_cmd_code  cmd;
        logic       hit;
        logic [4:0] col;
        logic [4:0] row;
        logic       known;
        logic [1:0] flag;
    } t_row;

    // predictor state
    logic [5:0]  cfg_cols, cfg_rows;
    logic [2:0]  cfg_tpp;
    logic        vmap [VERT_DEPTH];
    logic        tmap [TILE_DEPTH];
    logic [1:0]  pmap [TILE_DEPTH];
    int          vcount;
    logic        classified_q;
    int          pcols_l, prows_l;

    t_grid_res   res_q [$];
    int          n_fail, n_sent, n_got, n_class;
    bit          rx_on;

    function automatic int sat(int v, int hi);
        return v < 1 ? 1 : (v > hi ? hi : v);
    endfunction

    function automatic void restart_grid();
        vcount = 0;
        classified_q = 1'b0;
        pcols_l = 0;
        prows_l = 0;
        foreach (tmap[i]) tmap[i] = 1'b1;
        foreach (pmap[i]) pmap[i] = FLAG_HIT;
    endfunction

    function automatic logic vbit(int idx);
        return idx < VERT_DEPTH ? vmap[idx] : 1'b0;
    endfunction

    function automatic void build_maps(int cols, int rows, int tpp);
        int v, re, ce;
        bit aclr, ahit;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++) begin
                v = r * (cols + 1) + c;
                tmap[r * MAX_TILES_SIDE + c] = vbit(v) | vbit(v + 1) |
                    vbit(v + cols + 1) | vbit(v + cols + 2);
            end
        pcols_l = (cols + tpp - 1) / tpp;
        prows_l = (rows + tpp - 1) / tpp;
        for (int pr = 0; pr < prows_l; pr++)
            for (int pc = 0; pc < pcols_l; pc++) begin
                aclr = 1; ahit = 1;
                re = (pr * tpp + tpp > rows) ? rows : pr * tpp + tpp;
                ce = (pc * tpp + tpp > cols) ? cols : pc * tpp + tpp;
                for (int r = pr * tpp; r < re; r++)
                    for (int c = pc * tpp; c < ce; c++)
                        if (tmap[r * MAX_TILES_SIDE + c]) aclr = 0;
                        else ahit = 0;
                pmap[pr * MAX_TILES_SIDE + pc] = ahit ? FLAG_HIT :
                                                 (aclr ? FLAG_CLEAR : FLAG_MIXED);
            end
        classified_q = 1'b1;
    endfunction

    function automatic t_grid_res grid_step(t_cmd_code cmd, logic hit,
                                            logic [4:0] col, logic [4:0] row);
        int cols, rows, tpp;
        t_grid_res r;
        cols = sat(cfg_cols, MAX_TILES_SIDE);
        rows = sat(cfg_rows, MAX_TILES_SIDE);
        tpp  = sat(cfg_tpp, MAX_PATCH_SIDE);
        r.flag = FLAG_CLEAR;
        case (cmd)
            CMD_RESTART: restart_grid();
            CMD_LOAD: begin
                if (!classified_q) begin
                    if (vcount < VERT_DEPTH) begin
                        vmap[vcount] = hit;
                        vcount++;
                    end
                    if (vcount >= (cols + 1) * (rows + 1)) begin
                        vcount = (cols + 1) * (rows + 1);
                        build_maps(cols, rows, tpp);
                    end
                end
            end
            CMD_QTILE: if (col < cols && row < rows)
                r.flag = {1'b0, tmap[row * MAX_TILES_SIDE + col]};
            default: begin
                if (classified_q) begin
                    if (col < pcols_l && row < prows_l) r.flag = pmap[row * MAX_TILES_SIDE + col];
                end else r.flag = pmap[row * MAX_TILES_SIDE + col];
            end
        endcase
        r.classified = classified_q;
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[fluid_grid_clip_classifier_core] ERROR");
        $finish;
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_TILE_COLS: cfg_cols = val[5:0];
            REG_TILE_ROWS: cfg_rows = val[5:0];
            default:       cfg_tpp  = val[2:0];
        endcase
    endtask

    task automatic send_word(t_cmd_code cmd, logic hit, logic [4:0] col, logic [4:0] row,
                             bit known = 0, logic [1:0] kflag = FLAG_CLEAR);
        t_grid_res e;
        int gap;
        gap = $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, row, col, hit, cmd};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        e = grid_step(cmd, hit, col, row);
        if (known && e.flag != kflag) begin
            $error("table flag: expected %0d, predictor %0d", kflag, e.flag);
            n_fail++;
        end
        res_q = {res_q, e};
        n_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (res_q.size() != 0) @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    // receiver
    initial begin
        int gap;
        m_tready = 0;
        gap = 0;
        forever begin
            @(negedge i_clk);
            if (gap > 0) begin
                gap--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                gap = rx_on ? $urandom_range(0, 12) : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_grid_res e;
        if (i_rst_n && m_tvalid && m_tready) begin
            n_got++;
            if (m_tdata[2]) n_class++;
            if (res_q.size() == 0) begin
                $error("unexpected word %h", m_tdata);
                n_fail++;
            end else begin
                e = res_q.pop_front();
                if (m_tdata[1:0] != e.flag) begin
                    $error("flag: expected %0d, got %0d", e.flag, m_tdata[1:0]);
                    n_fail++;
                end
                if (m_tdata[2] != e.classified) begin
                    $error("classified: expected %0d, got %0d", e.classified, m_tdata[2]);
                    n_fail++;
                end
            end
        end
    end

    task automatic load_grid(int hp);
        int tot;
        tot = (sat(cfg_cols, 32) + 1) * (sat(cfg_rows, 32) + 1);
        for (int i = 0; i < tot; i++)
            send_word(CMD_LOAD, $urandom_range(0, 99) < hp, 5'($urandom), 5'($urandom));
    endtask

    t_row dir_tab [] = '{
        '{CMD_QPATCH,  1'b0, 5'd0,  5'd0,  1'b1, FLAG_HIT},
        '{CMD_QPATCH,  1'b0, 5'd31, 5'd31, 1'b1, FLAG_HIT},
        '{CMD_QTILE,   1'b0, 5'd0,  5'd0,  1'b1, FLAG_HIT},
        '{CMD_QTILE,   1'b0, 5'd1,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_QTILE,   1'b0, 5'd31, 5'd31, 1'b1, FLAG_CLEAR},
        '{CMD_LOAD,    1'b0, 5'd31, 5'd31, 1'b1, FLAG_CLEAR},
        '{CMD_LOAD,    1'b0, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_LOAD,    1'b0, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_LOAD,    1'b0, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_QTILE,   1'b0, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_QPATCH,  1'b0, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_QPATCH,  1'b0, 5'd1,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_LOAD,    1'b1, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_QTILE,   1'b0, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_RESTART, 1'b1, 5'd31, 5'd31, 1'b1, FLAG_CLEAR},
        '{CMD_QTILE,   1'b0, 5'd0,  5'd0,  1'b1, FLAG_HIT},
        '{CMD_LOAD,    1'b1, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_LOAD,    1'b0, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_LOAD,    1'b0, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_LOAD,    1'b0, 5'd0,  5'd0,  1'b1, FLAG_CLEAR},
        '{CMD_QTILE,   1'b0, 5'd0,  5'd0,  1'b1, FLAG_HIT},
        '{CMD_QPATCH,  1'b0, 5'd0,  5'd0,  1'b1, FLAG_HIT}
    };

    initial begin
        int op, hp;
        logic [5:0] cv [6];
        cv = '{6'd0, 6'd1, 6'd3, 6'd32, 6'd63, 6'd5};
        i_rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = 0;
        rx_on = 0; n_fail = 0; n_sent = 0; n_got = 0; n_class = 0;
        cfg_cols = 1; cfg_rows = 1; cfg_tpp = 7;
        foreach (vmap[i]) vmap[i] = 0;
        restart_grid();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        foreach (dir_tab[i])
            send_word(dir_tab[i].cmd, dir_tab[i].hit, dir_tab[i].col, dir_tab[i].row,
                      dir_tab[i].known, dir_tab[i].flag);
        wait_idle();
        rx_on = 1;

        // one wide grid, the rest small; some phases change size mid-load
        for (int ph = 0; n_sent < 850 || ph < 6; ph++) begin
            if (ph % 5 == 4) begin
                reg_write(REG_TILE_COLS, ph == 4 ? 32'd32 : ($urandom & 32'h3f));
                reg_write(REG_TILE_ROWS, ph == 4 ? 32'd8 : 32'd0);
            end else begin
                reg_write(REG_TILE_COLS,
                          {26'd0, cv[$urandom_range(0, 5)] & (ph % 2 ? 6'h7 : 6'h3f)});
                reg_write(REG_TILE_ROWS, $urandom_range(0, 7));
            end
            if (sat(cfg_cols, 32) * sat(cfg_rows, 32) > 256 && ph > 4)
                reg_write(REG_TILE_ROWS, 32'd2);
            reg_write(REG_TPP, ph % 7 == 0 ? 32'd0 : (ph % 7 == 1 ? 32'd7 : $urandom));
            hp = (ph % 3 == 0) ? 2 : ((ph % 3 == 1) ? 98 : 40);
            send_word(CMD_RESTART, 1'($urandom), 5'($urandom), 5'($urandom));
            load_grid(hp);
            for (int k = 0; k < 20; k++) begin
                op = $urandom_range(0, 9);
                if (op < 4)
                    send_word(CMD_QTILE, 1'($urandom), 5'($urandom_range(0, 9)),
                              5'($urandom_range(0, 9)));
                else if (op < 8)
                    send_word(CMD_QPATCH, 1'($urandom), 5'($urandom_range(0, 6)),
                              5'($urandom_range(0, 6)));
                else
                    send_word(t_cmd_code'($urandom_range(0, 3)), 1'($urandom),
                              5'($urandom), 5'($urandom));
            end
            if (ph % 4 == 3) begin
                // partial load, query before classification, then size change
                send_word(CMD_RESTART, 1'b0, 5'd0, 5'd0);
                for (int k = 0; k < 3; k++)
                    send_word(CMD_LOAD, 1'($urandom), 5'($urandom), 5'($urandom));
                send_word(CMD_QPATCH, 1'b0, 5'($urandom), 5'($urandom));
                wait_idle();
                reg_write(REG_TILE_COLS, 32'd1);
                reg_write(REG_TILE_ROWS, 32'd1);
                send_word(CMD_LOAD, 1'($urandom), 5'd0, 5'd0);
                send_word(CMD_QTILE, 1'b0, 5'd0, 5'd0);
            end
            wait_idle();
        end

        wait_idle();
        $display("Sent %0d words, checked %0d results (%0d after classification).",
                 n_sent, n_got, n_class);
        if (n_fail == 0)
            $display("[fluid_grid_clip_classifier_core] OK");
        else
            $display("[fluid_grid_clip_classifier_core] ERROR");
        $finish;
    end
endmodule
